/* src/rcfc_pkg.sv */
// Shared types, constants and codes for the radio-control frame checker and unpacker.
package rcfc_pkg;

    localparam int CHANNEL_COUNT     = 10;
    localparam int MAX_FRAME_BYTES   = 255;
    localparam int STORE_BYTES       = 2 * CHANNEL_COUNT;
    localparam int FIRST_PAYLOAD     = 4;
    localparam int CHECK_BYTES       = 4;
    localparam int MIN_CHANNEL_FRAME = FIRST_PAYLOAD + STORE_BYTES + CHECK_BYTES;
    localparam int QUEUE_DEPTH       = 2;

    localparam int POS_W   = 8;
    localparam int STORE_W = $clog2(STORE_BYTES);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HEADER_FIRST  = 8'hAA;
    localparam logic [7:0] HEADER_SECOND = 8'hAF;
    localparam logic [7:0] FUNC_CHANNELS = 8'h03;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_FUNCTION = 3'd3,
        ST_SHORT    = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } byte_word_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         channel_index;
        logic signed [15:0] channel_value;
        logic               last_result;
    } result_word_t;

    typedef struct packed {
        status_t                         status;
        logic [STORE_BYTES-1:0][7:0]     payload;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

endpackage

/* src/rcfc_if.sv */
// Valid/ready channel interfaces for frame bytes and unpacked results.
interface rcfc_byte_if;
    logic                valid;
    logic                ready;
    rcfc_pkg::byte_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcfc_result_if;
    logic                  valid;
    logic                  ready;
    rcfc_pkg::result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/rcfc_front.sv */
// Front part: byte intake, header and checksum tracking, payload capture, frame verdict.
module rcfc_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    rcfc_byte_if.sink               bytes,
    input  logic                    queue_full,
    output rcfc_pkg::job_push_t     job_push
);

    logic [rcfc_pkg::POS_W-1:0]                pos_reg, pos_next;
    logic [31:0]                               sum_reg, sum_next;
    logic [31:0]                               tail_reg, tail_next;
    logic                                      hdr_reg, hdr_next;
    logic [7:0]                                fn_reg, fn_next;
    logic [rcfc_pkg::STORE_BYTES-1:0][7:0]     store_reg;
    logic [rcfc_pkg::POS_W-1:0]                count;
    logic [rcfc_pkg::POS_W-1:0]                store_offset;
    logic                                      accept;
    logic                                      store_hit;
    logic [7:0]                                b;
    rcfc_pkg::status_t                         verdict;

    assign bytes.ready = !queue_full;
    assign accept      = bytes.valid && bytes.ready;
    assign b           = bytes.data.data_byte;
    assign store_offset = pos_reg - rcfc_pkg::POS_W'(rcfc_pkg::FIRST_PAYLOAD);
    assign store_hit   = (pos_reg >= rcfc_pkg::POS_W'(rcfc_pkg::FIRST_PAYLOAD))
                      && (pos_reg < rcfc_pkg::POS_W'(rcfc_pkg::FIRST_PAYLOAD
                                                     + rcfc_pkg::STORE_BYTES));

    always_comb
    begin
        sum_next  = (pos_reg >= rcfc_pkg::POS_W'(rcfc_pkg::FIRST_PAYLOAD))
                  ? sum_reg + {24'd0, tail_reg[31:24]} : sum_reg;
        tail_next = {tail_reg[23:0], b};
        hdr_next  = hdr_reg;
        if (pos_reg == rcfc_pkg::POS_W'(0) && b != rcfc_pkg::HEADER_FIRST)
        begin
            hdr_next = 1'b0;
        end
        if (pos_reg == rcfc_pkg::POS_W'(1) && b != rcfc_pkg::HEADER_SECOND)
        begin
            hdr_next = 1'b0;
        end
        fn_next = (pos_reg == rcfc_pkg::POS_W'(2)) ? b : fn_reg;
        count   = (pos_reg == rcfc_pkg::POS_W'(rcfc_pkg::MAX_FRAME_BYTES))
                ? pos_reg : pos_reg + rcfc_pkg::POS_W'(1);
        pos_next = count;

        priority if (count < rcfc_pkg::POS_W'(2) || !hdr_next)
        begin
            verdict = rcfc_pkg::ST_HEADER;
        end
        else if (count < rcfc_pkg::POS_W'(rcfc_pkg::CHECK_BYTES))
        begin
            verdict = rcfc_pkg::ST_SHORT;
        end
        else if (sum_next != tail_next)
        begin
            verdict = rcfc_pkg::ST_CHECKSUM;
        end
        else if (fn_next != rcfc_pkg::FUNC_CHANNELS)
        begin
            verdict = rcfc_pkg::ST_FUNCTION;
        end
        else if (count < rcfc_pkg::POS_W'(rcfc_pkg::MIN_CHANNEL_FRAME))
        begin
            verdict = rcfc_pkg::ST_SHORT;
        end
        else
        begin
            verdict = rcfc_pkg::ST_OK;
        end
    end

    assign job_push.push        = accept && bytes.data.frame_end;
    assign job_push.job.status  = verdict;
    assign job_push.job.payload = store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            tail_reg <= '0;
            hdr_reg  <= 1'b1;
            fn_reg   <= '0;
        end
        else if (accept)
        begin
            if (bytes.data.frame_end)
            begin
                pos_reg  <= '0;
                sum_reg  <= '0;
                tail_reg <= '0;
                hdr_reg  <= 1'b1;
                fn_reg   <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                tail_reg <= tail_next;
                hdr_reg  <= hdr_next;
                fn_reg   <= fn_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_hit)
        begin
            store_reg[store_offset[rcfc_pkg::STORE_W-1:0]] <= b;
        end
    end

endmodule

/* src/rcfc_queue.sv */
// Short job queue between the front and back parts.
module rcfc_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcfc_pkg::job_push_t   job_push,
    output logic                  full,
    output logic                  head_valid,
    output rcfc_pkg::job_t        head,
    input  logic                  pop
);

    rcfc_pkg::job_t                    entry_reg [rcfc_pkg::QUEUE_DEPTH];
    logic [rcfc_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [rcfc_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              do_push, do_pop;

    assign full       = (count_reg == rcfc_pkg::QCNT_W'(rcfc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = job_push.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + rcfc_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - rcfc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rcfc_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rcfc_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= job_push.job;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_push.push && full))
        else $error("job pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rcfc_pkg::QCNT_W'(rcfc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* src/rcfc_back.sv */
// Back part: turn queued frame verdicts into status or channel words behind an output register.
module rcfc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  rcfc_pkg::job_t        head,
    output logic                  pop,
    rcfc_result_if.source         results
);

    logic [3:0]              idx_reg, idx_next;
    logic                    out_valid_reg;
    rcfc_pkg::result_word_t  out_reg, out_next;
    logic                    load;
    logic                    is_status;
    logic                    last_channel;
    logic [rcfc_pkg::STORE_W-1:0] hi_sel, lo_sel;

    assign load         = !out_valid_reg || results.ready;
    assign is_status    = (head.status != rcfc_pkg::ST_OK);
    assign last_channel = (idx_reg == 4'(rcfc_pkg::CHANNEL_COUNT - 1));
    assign pop          = load && head_valid && (is_status || last_channel);
    assign hi_sel       = rcfc_pkg::STORE_W'({idx_reg, 1'b0});
    assign lo_sel       = rcfc_pkg::STORE_W'({idx_reg, 1'b1});

    always_comb
    begin
        out_next.status = head.status;
        if (is_status)
        begin
            out_next.channel_index = '0;
            out_next.channel_value = '0;
            out_next.last_result   = 1'b1;
        end
        else
        begin
            out_next.channel_index = idx_reg;
            out_next.channel_value = {head.payload[hi_sel], head.payload[lo_sel]};
            out_next.last_result   = last_channel;
        end
        idx_next = idx_reg;
        if (load && head_valid)
        begin
            idx_next = pop ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < 4'(rcfc_pkg::CHANNEL_COUNT))
        else $error("channel counter out of range");

    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != rcfc_pkg::ST_OK |->
            out_reg.last_result && out_reg.channel_index == '0 && out_reg.channel_value == '0)
        else $error("status word malformed");

    a_channel_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == rcfc_pkg::ST_OK |->
            out_reg.last_result == (out_reg.channel_index == 4'(rcfc_pkg::CHANNEL_COUNT - 1)))
        else $error("last marker on wrong channel");

endmodule

/* src/rc_frame_check_and_unpack_top.sv */
// Top level of the radio-control frame checker and unpacker.
//
// The bytes channel takes one frame byte per word, frame_end set on the final byte.
// The front part checks the 0xAA 0xAF header, sums every byte but the last four and
// compares that sum with the big-endian checksum in them, and keeps bytes 4 to 23.
// At the final byte it pushes a verdict and the payload into a two-entry queue.
// The back part drains the queue into the results channel: one status word for a
// bad, foreign or short frame, or ten channel words (throttle, yaw, roll, pitch,
// aux1..aux6) for a good channel frame, the last one marked.
// Throughput: one byte per cycle at the input while the queue is not full; one result
// word per cycle at the output while the receiver is ready, set by the single output
// register, so a channel frame holds the back part for ten words. A frame's verdict
// is registered in a queue entry, then its first result word in the output register.
// A stalled receiver holds the output word; bytes keep being taken until the queue
// holds two finished frames, then ready drops until the back part frees an entry.
// Reset clears the frame tracking, the queue and the output; no clearing pass.
module rc_frame_check_and_unpack_top
(
    input  logic           clk,
    input  logic           rst_n,
    rcfc_byte_if.sink      bytes,
    rcfc_result_if.source  results
);

    rcfc_pkg::job_push_t job_push;
    rcfc_pkg::job_t      head;
    logic                queue_full;
    logic                head_valid;
    logic                pop;

    rcfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .queue_full (queue_full),
        .job_push   (job_push)
    );

    rcfc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_push   (job_push),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    rcfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

/* dv/rc_frame_check_and_unpack_top_test.sv */
// Testbench for the radio-control frame checker and unpacker: frame stimulus and result checks.
`timescale 1ns / 100ps

class rc_frame_scoreboard;
    logic [7:0]             byte_count;
    logic [31:0]            byte_sum;
    logic [31:0]            tail_bytes;
    logic                   header_ok;
    logic [7:0]             func_code;
    logic [7:0]             payload [rcfc_pkg::STORE_BYTES];
    rcfc_pkg::result_word_t expected_words [$];
    int                     mismatches;
    int                     checked;

    function new();
        clear_frame();
        foreach (payload[i])
        begin
            payload[i] = 8'h00;
        end
        mismatches = 0;
        checked    = 0;
    endfunction

    function void clear_frame();
        byte_count = 8'd0;
        byte_sum   = 32'd0;
        tail_bytes = 32'd0;
        header_ok  = 1'b1;
        func_code  = 8'd0;
    endfunction

    function void push_status(rcfc_pkg::status_t code);
        rcfc_pkg::result_word_t w;
        w.status        = code;
        w.channel_index = 4'd0;
        w.channel_value = 16'sd0;
        w.last_result   = 1'b1;
        expected_words.push_back(w);
    endfunction

    function void note_byte(rcfc_pkg::byte_word_t w);
        int                     pos;
        int                     count;
        logic [31:0]            sum_now;
        logic [31:0]            check_now;
        logic                   hdr_now;
        logic [7:0]             fn_now;
        rcfc_pkg::result_word_t chan;
        pos = byte_count;
        if (pos == 0 && w.data_byte != rcfc_pkg::HEADER_FIRST)
        begin
            header_ok = 1'b0;
        end
        if (pos == 1 && w.data_byte != rcfc_pkg::HEADER_SECOND)
        begin
            header_ok = 1'b0;
        end
        if (pos == 2)
        begin
            func_code = w.data_byte;
        end
        if (pos >= rcfc_pkg::FIRST_PAYLOAD
            && pos < rcfc_pkg::FIRST_PAYLOAD + rcfc_pkg::STORE_BYTES)
        begin
            payload[pos - rcfc_pkg::FIRST_PAYLOAD] = w.data_byte;
        end
        if (pos >= rcfc_pkg::CHECK_BYTES)
        begin
            byte_sum = byte_sum + {24'd0, tail_bytes[31:24]};
        end
        tail_bytes = {tail_bytes[23:0], w.data_byte};
        count      = (pos + 1 > rcfc_pkg::MAX_FRAME_BYTES) ? rcfc_pkg::MAX_FRAME_BYTES : pos + 1;
        byte_count = count[7:0];
        if (!w.frame_end)
        begin
            return;
        end
        sum_now   = byte_sum;
        check_now = tail_bytes;
        hdr_now   = header_ok;
        fn_now    = func_code;
        clear_frame();
        if (count < 2 || !hdr_now)
        begin
            push_status(rcfc_pkg::ST_HEADER);
        end
        else if (count < rcfc_pkg::CHECK_BYTES)
        begin
            push_status(rcfc_pkg::ST_SHORT);
        end
        else if (sum_now != check_now)
        begin
            push_status(rcfc_pkg::ST_CHECKSUM);
        end
        else if (fn_now != rcfc_pkg::FUNC_CHANNELS)
        begin
            push_status(rcfc_pkg::ST_FUNCTION);
        end
        else if (count < rcfc_pkg::MIN_CHANNEL_FRAME)
        begin
            push_status(rcfc_pkg::ST_SHORT);
        end
        else
        begin
            for (int k = 0; k < rcfc_pkg::CHANNEL_COUNT; k++)
            begin
                chan.status        = rcfc_pkg::ST_OK;
                chan.channel_index = 4'(k);
                chan.channel_value = {payload[2 * k], payload[2 * k + 1]};
                chan.last_result   = (k == rcfc_pkg::CHANNEL_COUNT - 1);
                expected_words.push_back(chan);
            end
        end
    endfunction

    function void check_word(rcfc_pkg::result_word_t got);
        rcfc_pkg::result_word_t want;
        checked++;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: unexpected result word status=%0d index=%0d value=%0d last=%0d",
                         $realtime, got.status, got.channel_index, got.channel_value,
                         got.last_result);
            end
            return;
        end
        want = expected_words.pop_front();
        if (got.status != want.status || got.channel_index != want.channel_index ||
            got.channel_value != want.channel_value || got.last_result != want.last_result)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: result mismatch, expected status=%0d index=%0d value=%0d last=%0d",
                         $realtime, want.status, want.channel_index, want.channel_value,
                         want.last_result);
                $display("%0t:                    got status=%0d index=%0d value=%0d last=%0d",
                         $realtime, got.status, got.channel_index, got.channel_value,
                         got.last_result);
            end
        end
    endfunction

    function void close_out();
        if (expected_words.size() != 0)
        begin
            $display("%0d expected result words never arrived", expected_words.size());
            mismatches += expected_words.size();
        end
    endfunction
endclass

module rc_frame_check_and_unpack_top_test;

    logic clk;
    logic rst_n;

    rcfc_byte_if   bytes_ch ();
    rcfc_result_if results_ch ();

    rc_frame_check_and_unpack_top u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_ch),
        .results (results_ch)
    );

    rc_frame_scoreboard sb = new();

    logic [7:0] frame_q [$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_request   = 0;
    int         hold_left      = 0;
    int         frames_sent    = 0;
    int         bytes_taken    = 0;
    int         input_stalls   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bytes_ch.valid && bytes_ch.ready)
            begin
                sb.note_byte(bytes_ch.data);
                bytes_taken++;
            end
            if (bytes_ch.valid && !bytes_ch.ready)
            begin
                input_stalls++;
            end
            if (results_ch.valid && results_ch.ready)
            begin
                sb.check_word(results_ch.data);
            end
        end
    end

    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                results_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        rcfc_pkg::byte_word_t w;
        w.data_byte = value;
        w.frame_end = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            bytes_ch.valid <= 1'b0;
            @(negedge clk);
        end
        bytes_ch.valid <= 1'b1;
        bytes_ch.data  <= w;
        @(posedge clk);
        while (!bytes_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
        begin
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic start_frame(input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] fn);
        frame_q.delete();
        frame_q.push_back(h0);
        frame_q.push_back(h1);
        frame_q.push_back(fn);
        frame_q.push_back(8'($urandom));
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            frame_q.push_back(8'($urandom));
        end
    endtask

    task automatic seal_frame();
        logic [31:0] sum;
        sum = 32'd0;
        foreach (frame_q[i])
        begin
            sum = sum + {24'd0, frame_q[i]};
        end
        frame_q.push_back(sum[31:24]);
        frame_q.push_back(sum[23:16]);
        frame_q.push_back(sum[15:8]);
        frame_q.push_back(sum[7:0]);
    endtask

    initial
    begin
        logic [15:0] extremes [rcfc_pkg::CHANNEL_COUNT];

        extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                     16'hFFFE, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA};

        rst_n          = 1'b0;
        bytes_ch.valid = 1'b0;
        bytes_ch.data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        start_frame(rcfc_pkg::HEADER_FIRST, rcfc_pkg::HEADER_SECOND, rcfc_pkg::FUNC_CHANNELS);
        foreach (extremes[i])
        begin
            frame_q.push_back(extremes[i][15:8]);
            frame_q.push_back(extremes[i][7:0]);
        end
        seal_frame();
        send_frame();

        start_frame(8'hAB, rcfc_pkg::HEADER_SECOND, rcfc_pkg::FUNC_CHANNELS);
        seal_frame();
        send_frame();

        // sender idle most of the time
        send_idle_pct = 88;
        frame_q.delete();
        frame_q.push_back(rcfc_pkg::HEADER_FIRST);
        send_frame();

        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();

        frame_q.delete();
        frame_q.push_back(rcfc_pkg::HEADER_FIRST);
        frame_q.push_back(rcfc_pkg::HEADER_SECOND);
        send_frame();

        frame_q.push_back(rcfc_pkg::FUNC_CHANNELS);
        send_frame();

        frame_q.push_back(8'h00);
        send_frame();

        start_frame(rcfc_pkg::HEADER_FIRST, 8'h00, rcfc_pkg::FUNC_CHANNELS);
        seal_frame();
        send_frame();

        // receiver stalling most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        start_frame(rcfc_pkg::HEADER_FIRST, rcfc_pkg::HEADER_SECOND, rcfc_pkg::FUNC_CHANNELS);
        seal_frame();
        frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h01;
        send_frame();

        start_frame(rcfc_pkg::HEADER_FIRST, rcfc_pkg::HEADER_SECOND, 8'h00);
        seal_frame();
        send_frame();

        start_frame(rcfc_pkg::HEADER_FIRST, rcfc_pkg::HEADER_SECOND, rcfc_pkg::FUNC_CHANNELS);
        seal_frame();
        send_frame();

        // hold the receiver off and offer six short frames so that the input stalls
        recv_stall_pct = 0;
        hold_request   = 200;
        repeat (6)
        begin
            frame_q.delete();
            frame_q.push_back(rcfc_pkg::HEADER_FIRST);
            frame_q.push_back(rcfc_pkg::HEADER_SECOND);
            send_frame();
        end

        // both sides idle now and then
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        start_frame(rcfc_pkg::HEADER_FIRST, rcfc_pkg::HEADER_SECOND, rcfc_pkg::FUNC_CHANNELS);
        add_random(rcfc_pkg::STORE_BYTES + $urandom_range(0, 3));
        seal_frame();
        send_frame();

        bytes_ch.valid <= 1'b0;
        while (sb.expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        sb.close_out();

        $display("Ran %0d frames (%0d bytes) through header, length, checksum and function cases,",
                 frames_sent, bytes_taken);
        $display("under four idling patterns and one long hold-off: %0d words, %0d stall cycles",
                 sb.checked, input_stalls);
        if (sb.mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
